// ===== hw/rtl/pem_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pem_pkg
// Types and fixed constants of the Prewitt RGB edge magnitude block.
// ----------------------------------------------------------------------------
package pem_pkg;

  localparam int NUM_CH       = 3;
  localparam int CH_W         = 8;
  localparam int RGB_W        = NUM_CH * CH_W;
  localparam int SUM_W        = CH_W + 2;     // sum of three samples
  localparam int GRAD_W       = SUM_W + 1;    // signed difference of two sums
  localparam int SQ_W         = 2 * GRAD_W - 1;
  localparam int ROOT_IN_W    = 2 * CH_W;     // magnitude squared below saturation
  localparam int ROOT_STEPS   = CH_W;
  localparam int STEP_W       = $clog2(ROOT_STEPS);
  localparam int REM_W        = CH_W + 2;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int COL_OUT_W    = 10;
  localparam int ROW_OUT_W    = 12;
  localparam int MIN_SIZE     = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_SEL_BIT = 2;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [RGB_W-1:0] rgb_t;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            frame_start;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]      red_edge;
    logic [CH_W-1:0]      green_edge;
    logic [CH_W-1:0]      blue_edge;
    logic [COL_OUT_W-1:0] out_column;
    logic [ROW_OUT_W-1:0] out_row;
    logic                 frame_end;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_PUSH
  } state_t;

  // zero-extended sample of one channel from a packed pixel
  function automatic logic [SUM_W-1:0] chan(input rgb_t px, input int c);
    return SUM_W'(px[CH_W*c +: CH_W]);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pem_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pem_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface pem_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/prewitt_edge_magnitude_rgb_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_rgb_unit
// Prewitt 3x3 gradient magnitude per RGB channel over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels come in raster order on the pixel channel; every pixel not in the
// first two rows or columns gives one request on the result
// channel with floor(sqrt(gx^2 + gy^2)) per channel, saturated at 255, and the
// position of the window centre. Both rows above the incoming pixel live in
// one line memory of MAX_WIDTH words of two pixels each, read into a register
// as a pixel is taken and written back in the next cycle; it needs no clearing
// after reset. A pixel that gives no result goes through the line memory read
// and write-back; one that gives a result goes through read, gradient, squares,
// eight square-root steps of one result bit each, and the load of the output
// register, which holds a finished result while the next pixel is taken.
// image_width (0x0) and image_height (0x4) are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT; the user must write them only while idle (block does not enforce).
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  pem_stream_if.sink                      pixel,
  pem_stream_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pem_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pem_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pem_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pem_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WU_W = CW + 1;
  localparam int HU_W = RW + 1;

  // configuration
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic                    cfg_write;
  reg_index_t              cfg_sel;
  logic [WU_W-1:0]         w_use;
  logic [HU_W-1:0]         h_use;
  logic [WU_W-1:0]         w_last;
  logic [HU_W-1:0]         h_last;

  // control
  state_t                  state;
  state_t                  state_next;
  logic                    accept;
  logic                    mem_we;
  logic                    load_result;
  logic                    root_last;

  // position
  pixel_t                  px_in;
  logic [CW-1:0]           column_count;
  logic [RW-1:0]           row_count;
  logic [CW-1:0]           col_eff;
  logic [RW-1:0]           row_eff;
  logic                    last_col;
  logic                    last_row;
  logic                    has_result;

  // captured request
  rgb_t                    cur_px;
  logic [CW-1:0]           idx;
  logic                    has_result_q;
  logic [COL_OUT_W-1:0]    out_col_q;
  logic [ROW_OUT_W-1:0]    out_row_q;
  logic                    frame_end_q;

  // line memory: [2*RGB_W-1:RGB_W] previous row, [RGB_W-1:0] older row
  logic [2*RGB_W-1:0]      line_mem [MAX_WIDTH];
  logic [2*RGB_W-1:0]      line_rd;
  rgb_t                    top;
  rgb_t                    mid;
  rgb_t                    win [6];

  // arithmetic
  logic [SUM_W-1:0]            sum_r [NUM_CH];
  logic [SUM_W-1:0]            sum_l [NUM_CH];
  logic [SUM_W-1:0]            sum_b [NUM_CH];
  logic [SUM_W-1:0]            sum_t [NUM_CH];
  logic signed [GRAD_W-1:0]    gx_next [NUM_CH];
  logic signed [GRAD_W-1:0]    gy_next [NUM_CH];
  logic signed [GRAD_W-1:0]    gx [NUM_CH];
  logic signed [GRAD_W-1:0]    gy [NUM_CH];
  logic signed [2*GRAD_W-1:0]  sqx [NUM_CH];
  logic signed [2*GRAD_W-1:0]  sqy [NUM_CH];
  logic [SQ_W-1:0]             sq_sum [NUM_CH];
  logic [ROOT_IN_W-1:0]        root_in [NUM_CH];
  logic                        root_sat [NUM_CH];
  logic [REM_W-1:0]            rem [NUM_CH];
  logic [CH_W-1:0]             res [NUM_CH];
  logic [REM_W+1:0]            cand [NUM_CH];
  logic [REM_W+1:0]            trial [NUM_CH];
  logic [REM_W-1:0]            rem_next [NUM_CH];
  logic [CH_W-1:0]             res_next [NUM_CH];
  logic [CH_W-1:0]             mag [NUM_CH];
  logic [STEP_W-1:0]           root_step;

  // output register
  logic                    out_valid;
  result_t                 out_data;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_index_t'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width < WIDTH_REG_W'(MIN_SIZE)) begin
      w_use = WU_W'(MIN_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_use = WU_W'(MAX_WIDTH);
    end else begin
      w_use = WU_W'(image_width);
    end
    if (image_height < HEIGHT_REG_W'(MIN_SIZE)) begin
      h_use = HU_W'(MIN_SIZE);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_use = HU_W'(MAX_HEIGHT);
    end else begin
      h_use = HU_W'(image_height);
    end
    w_last = w_use - WU_W'(1);
    h_last = h_use - HU_W'(1);
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  assign px_in     = pixel.data;
  assign accept    = pixel.valid && pixel.ready;
  assign root_last = (root_step == STEP_W'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pixel.ready = 1'b0;
    mem_we      = 1'b0;
    load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        pixel.ready = 1'b1;
        if (pixel.valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_we     = 1'b1;
        state_next = has_result_q ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_last) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid || result.ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // position
  // --------------------------------------------------------------------------
  always_comb begin
    col_eff    = px_in.frame_start ? '0 : column_count;
    row_eff    = px_in.frame_start ? '0 : row_count;
    last_col   = WU_W'(col_eff) >= w_last;
    last_row   = HU_W'(row_eff) >= h_last;
    has_result = (col_eff >= CW'(2)) && (row_eff >= RW'(2)) &&
                 (WU_W'(col_eff) < w_use) && (HU_W'(row_eff) < h_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      has_result_q <= 1'b0;
    end else if (accept) begin
      has_result_q <= has_result;
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_eff + RW'(1);
      end else begin
        column_count <= col_eff + CW'(1);
        row_count    <= row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_px      <= {px_in.blue_in, px_in.green_in, px_in.red_in};
      idx         <= col_eff;
      out_col_q   <= COL_OUT_W'(col_eff - CW'(1));
      out_row_q   <= ROW_OUT_W'(row_eff - RW'(1));
      frame_end_q <= (WU_W'(col_eff) == w_last) && (HU_W'(row_eff) == h_last);
    end
  end

  // --------------------------------------------------------------------------
  // line memory: read on accept, write back the shifted rows in the next cycle (ST_READ), not later
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[idx] <= {cur_px, mid};
    end
  end

  assign top = line_rd[RGB_W-1:0];
  assign mid = line_rd[2*RGB_W-1:RGB_W];

  // window holds the two columns left of the incoming pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (mem_we) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= cur_px;
    end
  end

  // --------------------------------------------------------------------------
  // gradients, squares and bit-serial square root per channel
  // --------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_r[c]   = chan(top, c) + chan(mid, c) + chan(cur_px, c);
      sum_l[c]   = chan(win[0], c) + chan(win[1], c) + chan(win[2], c);
      sum_b[c]   = chan(win[2], c) + chan(win[5], c) + chan(cur_px, c);
      sum_t[c]   = chan(win[0], c) + chan(win[3], c) + chan(top, c);
      gx_next[c] = $signed({1'b0, sum_r[c]}) - $signed({1'b0, sum_l[c]});
      gy_next[c] = $signed({1'b0, sum_b[c]}) - $signed({1'b0, sum_t[c]});
      sqx[c]     = gx[c] * gx[c];
      sqy[c]     = gy[c] * gy[c];
      sq_sum[c]  = SQ_W'(sqx[c]) + SQ_W'(sqy[c]);
      // one result bit: bring down two bits, try (res << 2) | 1
      cand[c]    = {rem[c], root_in[c][ROOT_IN_W-1 -: 2]};
      trial[c]   = {2'b00, res[c], 2'b01};
      if (cand[c] >= trial[c]) begin
        rem_next[c] = REM_W'(cand[c] - trial[c]);
        res_next[c] = {res[c][CH_W-2:0], 1'b1};
      end else begin
        rem_next[c] = REM_W'(cand[c]);
        res_next[c] = {res[c][CH_W-2:0], 1'b0};
      end
      mag[c]     = root_sat[c] ? '1 : res[c];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_READ: begin
        for (int c = 0; c < NUM_CH; c++) begin
          gx[c] <= gx_next[c];
          gy[c] <= gy_next[c];
        end
      end
      ST_SQUARE: begin
        root_step <= '0;
        for (int c = 0; c < NUM_CH; c++) begin
          root_in[c]  <= sq_sum[c][ROOT_IN_W-1:0];
          root_sat[c] <= |sq_sum[c][SQ_W-1:ROOT_IN_W];
          rem[c]      <= '0;
          res[c]      <= '0;
        end
      end
      ST_ROOT: begin
        root_step <= root_step + STEP_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
          root_in[c] <= {root_in[c][ROOT_IN_W-3:0], 2'b00};
          rem[c]     <= rem_next[c];
          res[c]     <= res_next[c];
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_data.red_edge   <= mag[0];
      out_data.green_edge <= mag[1];
      out_data.blue_edge  <= mag[2];
      out_data.out_column <= out_col_q;
      out_data.out_row    <= out_row_q;
      out_data.frame_end  <= frame_end_q;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(column_count) < MAX_WIDTH)
    else $error("column counter beyond line memory depth");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_READ && mem_we))
    else $error("accepted pixel not followed by line memory write-back");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && pixel.ready))
    else $error("line memory write-back overlaps a new read");

  a_border_skips: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && !has_result_q) |=> (state == ST_IDLE))
    else $error("border pixel entered the magnitude path");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_result |=> (result.valid && result.data.frame_end == $past(frame_end_q)))
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

// ===== tb/prewitt_edge_magnitude_rgb_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_rgb_unit_tb
// Streams RGB frames of many sizes through the edge unit and checks every
// result request against a predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_rgb_unit_tb;
  import pem_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int FILL_W = 64;
  localparam int RANDOM_PIXELS = 660;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 300;

  // predictor of the 3x3 window and the queue of edge results still due
  class edge_scoreboard;
    rgb_t                    line_prev [MAX_W];
    rgb_t                    line_older[MAX_W];
    rgb_t                    win[6];
    int                      col_pos;
    int                      row_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    result_t                 expected_edges[$];
    int                      errors;

    function new();
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
    endfunction

    function int size_in_use(int v, int hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int sample(rgb_t px, int c);
      return int'(px[CH_W*c +: CH_W]);
    endfunction

    function void write_reg(reg_index_t idx, logic [APB_DATA_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = v[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = v[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(pixel_t p);
      rgb_t            cur, top, mid;
      int              w, h, idx, gx, gy, sq, root;
      logic [CH_W-1:0] mag[NUM_CH];
      result_t         r;
      w = size_in_use(int'(width_reg), MAX_W);
      h = size_in_use(int'(height_reg), MAX_H);
      if (p.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      cur = {p.blue_in, p.green_in, p.red_in};
      idx = col_pos % MAX_W;
      top = line_older[idx];
      mid = line_prev[idx];
      if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
        for (int c = 0; c < NUM_CH; c++) begin
          gx = sample(top, c) + sample(mid, c) + sample(cur, c)
             - sample(win[0], c) - sample(win[1], c) - sample(win[2], c);
          gy = sample(win[2], c) + sample(win[5], c) + sample(cur, c)
             - sample(win[0], c) - sample(win[3], c) - sample(top, c);
          sq = gx * gx + gy * gy;
          root = 0;
          // bit by bit integer root, 11 bits covers 2 * 765^2
          for (int b = 10; b >= 0; b--) begin
            if ((root + (1 << b)) * (root + (1 << b)) <= sq) root += (1 << b);
          end
          mag[c] = (root > 255) ? 8'd255 : CH_W'(root);
        end
        r.red_edge   = mag[0];
        r.green_edge = mag[1];
        r.blue_edge  = mag[2];
        r.out_column = COL_OUT_W'(col_pos - 1);
        r.out_row    = ROW_OUT_W'(row_pos - 1);
        r.frame_end  = (col_pos == w - 1 && row_pos == h - 1);
        expected_edges.push_back(r);
      end
      line_older[idx] = mid;
      line_prev[idx]  = cur;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = cur;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) row_pos = 0;
        else row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    function void report_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (expected_edges.size() == 0) begin
        $display("%0t: result expected none actual col %0d row %0d", $time,
                 got.out_column, got.out_row);
        errors++;
      end else begin
        want = expected_edges.pop_front();
        report_field("red_edge", want.red_edge, got.red_edge);
        report_field("green_edge", want.green_edge, got.green_edge);
        report_field("blue_edge", want.blue_edge, got.blue_edge);
        report_field("out_column", want.out_column, got.out_column);
        report_field("out_row", want.out_row, got.out_row);
        report_field("frame_end", want.frame_end, got.frame_end);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  bit                    hold_request;
  edge_scoreboard        sb;

  pem_stream_if #(.payload_t(pixel_t))  pix_if ();
  pem_stream_if #(.payload_t(result_t)) res_if ();

  prewitt_edge_magnitude_rgb_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic pixel_t mk_pixel(int r, int g, int b, bit fs);
    pixel_t p;
    p.red_in      = CH_W'(r);
    p.green_in    = CH_W'(g);
    p.blue_in     = CH_W'(b);
    p.frame_start = fs;
    return p;
  endfunction

  // 0,1: uniform noise; 2: nearly flat; 3: only black and full scale
  function automatic pixel_t random_pixel(int content);
    case (content)
      2: return mk_pixel(120 + $urandom_range(0, 6), 120 + $urandom_range(0, 6),
                         120 + $urandom_range(0, 6), 1'b0);
      3: return mk_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                         $urandom_range(0, 1) * 255, 1'b0);
      default: return mk_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), 1'b0);
    endcase
  endfunction

  task automatic apb_read(reg_index_t idx);
    logic [APB_DATA_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == REG_IMAGE_WIDTH) ? APB_DATA_W'(sb.width_reg) : APB_DATA_W'(sb.height_reg);
    if (prdata !== want) begin
      $display("%0t: register %s expected %0d actual %0d", $time, idx.name(), want, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(reg_index_t idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apb_read(idx);
  endtask

  task automatic push_pixel(pixel_t p);
    @(negedge clk);
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sb.take_pixel(p);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
      pix_if.data  <= random_pixel(0);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_edges.size() != 0) @(posedge clk);
  endtask

  // registers change only once the pipeline has emptied
  task automatic settle_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic stream_pixels(int count, bit lead_fs, int content, bit no_gaps,
                               bit mid_fs);
    int     burst_left;
    pixel_t p;
    burst_left = no_gaps ? count : $urandom_range(1, 24);
    for (int sent = 0; sent < count; sent++) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 64) : $urandom_range(1, 24);
      end
      p = random_pixel(content);
      p.frame_start = (sent == 0) ? lead_fs : (mid_fs && $urandom_range(0, 99) == 0);
      push_pixel(p);
      burst_left--;
    end
    idle_sender(1);
  endtask

  // result side: ready follows a changing pattern, with one long hold-off
  initial begin : sink_side
    int  sink_mode;
    int  mode_left;
    int  beat;
    int  hold_left;
    bit  rdy;
    sink_mode = 0;
    mode_left = 0;
    beat      = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        beat++;
        case (sink_mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = (beat % 7) < 4;
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) sb.match_result(res_if.data);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int                    random_items;
    int                    phase_no;
    int                    n;
    int                    content;
    int                    v;
    bit                    lead;
    sb           = new();
    hold_request = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_read(REG_IMAGE_WIDTH);
    apb_read(REG_IMAGE_HEIGHT);

    // widest rows used later first so that both line stores are written there
    // before any result reads them; the height is past the top of the clamp
    apb_write(REG_IMAGE_WIDTH, 32'hA5A5_0000 | FILL_W);
    apb_write(REG_IMAGE_HEIGHT, 32'h5A5A_0000 | 32'd8191);
    stream_pixels(2 * FILL_W, 1'b1, 0, 1'b0, 1'b0);
    @(posedge clk);
    hold_request = 1'b1;
    // third row gives results out to the last column while the sink holds off
    stream_pixels(FILL_W, 1'b0, 0, 1'b1, 1'b0);

    // 3x3 frames: saturating, negative gradient, small magnitude, wrap of frame
    settle_idle();
    apb_write(REG_IMAGE_WIDTH, 32'd3);
    apb_write(REG_IMAGE_HEIGHT, 32'd3);
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        push_pixel(mk_pixel(cc == 2 ? 255 : 0, rr == 2 ? 255 : 0, 255, rr == 0 && cc == 0));
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        push_pixel(mk_pixel(cc == 0 ? 255 : 0, rr * 3 + cc,
                            rr == 0 ? 255 : (rr == 1 ? 100 : 0), 1'b0));
    idle_sender(1);

    // sizes below the clamp; magnitude right at and just past 255
    settle_idle();
    apb_write(REG_IMAGE_WIDTH, 32'd0);
    apb_write(REG_IMAGE_HEIGHT, 32'd1);
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        push_pixel(mk_pixel(cc == 2 ? 85 : 0, cc == 2 ? 86 : 0, ((rr + cc) % 2) * 255,
                            rr == 0 && cc == 0));
    idle_sender(1);

    random_items = 0;
    phase_no     = 0;
    while (random_items < RANDOM_PIXELS) begin
      settle_idle();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: v = $urandom_range(0, 2);
          1: v = $urandom_range(13, FILL_W);
          2: v = $urandom_range(0, 1) ? MAX_W : $urandom_range(MAX_W + 1, 2047);
          default: v = $urandom_range(3, 12);
        endcase
        apb_write(REG_IMAGE_WIDTH, ($urandom() & 32'hFFFF_F800) | v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: v = $urandom_range(0, 2);
          1: v = $urandom_range(9, 40);
          2: v = $urandom_range(0, 1) ? MAX_H : $urandom_range(MAX_H + 1, 8191);
          default: v = $urandom_range(3, 8);
        endcase
        apb_write(REG_IMAGE_HEIGHT, ($urandom() & 32'hFFFF_E000) | v);
      end
      n       = $urandom_range(10, 120);
      content = $urandom_range(0, 3);
      // without a frame start the position carries over, possibly past a shrunk size;
      // rows wider than the filled part of the line stores always start a new frame
      lead    = ($urandom_range(0, 3) != 0) ||
                (sb.size_in_use(int'(sb.width_reg), MAX_W) > FILL_W);
      if (phase_no == 2) begin
        stream_pixels(n / 2, lead, content, 1'b0, 1'b1);
        wait_drained();
        stream_pixels(n - n / 2, 1'b0, content, 1'b0, 1'b1);
      end else begin
        stream_pixels(n, lead, content, 1'b0, 1'b1);
      end
      random_items += n;
      phase_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (sb.errors == 0 && sb.expected_edges.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/pem_pkg.sv
hw/rtl/pem_stream_if.sv
hw/rtl/prewitt_edge_magnitude_rgb_unit.sv
tb/prewitt_edge_magnitude_rgb_unit_tb.sv
